// ===== rtl/core/swap_block_table_allocator_unit_macros.svh =====
// Assertion macros for the allocator RTL.
// Depends on nothing; include from inside a module body.
`ifndef SWAP_BLOCK_TABLE_ALLOCATOR_UNIT_MACROS_SVH
`define SWAP_BLOCK_TABLE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SBTA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SBTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/sbta_pkg.sv =====
// Shared types and constants for the swap block table allocator.
// No dependencies.
package sbta_pkg;

  localparam int SIZE_W     = 32;
  localparam int FIELD_ID_W = 24;
  localparam int STATUS_W   = 3;
  localparam int USED_W     = 7;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BLOCKS = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DISABLED = 3'd1,
    ST_FULL     = 3'd2,
    ST_NO_ENTRY = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

endpackage

// ===== rtl/core/sbta_req_if.sv =====
// Request channel: allocate / free transactions with valid/ready.
// Depends on sbta_pkg.
interface sbta_req_if;
  import sbta_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [SIZE_W-1:0]     size_bytes;
  logic [FIELD_ID_W-1:0] free_block_id;

  modport source (output valid, operation, size_bytes, free_block_id, input ready);
  modport sink   (input valid, operation, size_bytes, free_block_id, output ready);
endinterface

// ===== rtl/core/sbta_rsp_if.sv =====
// Response channel: one result transaction per request, valid/ready.
// Depends on sbta_pkg.
interface sbta_rsp_if;
  import sbta_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_ID_W-1:0] block_id;
  logic [STATUS_W-1:0]   status;
  logic [USED_W-1:0]     entry_count;
  logic [FIELD_ID_W-1:0] next_block;

  modport source (output valid, block_id, status, entry_count, next_block, input ready);
  modport sink   (input valid, block_id, status, entry_count, next_block, output ready);
endinterface

// ===== rtl/core/sbta_table_mem.sv =====
// Entry table storage: one write port, one read port, registered read data.
// No package dependencies.
module sbta_table_mem #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 25,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/sbta_engine.sv =====
// Request sequencer: clearing pass, bounds check, table scan, write-back
// and the response register. Depends on sbta_pkg, the channel interfaces
// and the assertion macro header.
module sbta_engine #(
  parameter int ENTRIES          = 64,
  parameter int BLOCK_BYTES_LOG2 = 12,
  parameter int BLOCK_ID_BITS    = 24,
  parameter int IDX_W            = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             swap_enable,
  input  logic [sbta_pkg::CFG_W-1:0]       region_blocks,
  sbta_req_if.sink                         req,
  sbta_rsp_if.source                       rsp,
  output logic                             mem_wr_en,
  output logic [IDX_W-1:0]                 mem_wr_addr,
  output logic [BLOCK_ID_BITS:0]           mem_wr_data,
  output logic [IDX_W-1:0]                 mem_rd_addr,
  input  logic [BLOCK_ID_BITS:0]           mem_rd_data
);
  import sbta_pkg::*;

  localparam int ID_W  = BLOCK_ID_BITS;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int BLK_W = SIZE_W + 1 - BLOCK_BYTES_LOG2;
  localparam int MX1   = (ID_W > BLK_W) ? ID_W : BLK_W;
  localparam int MX2   = (MX1 > CFG_W) ? MX1 : CFG_W;
  localparam int SUM_W = MX2 + 1;
  localparam int CMP_W = (ID_W > FIELD_ID_W) ? ID_W : FIELD_ID_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [SIZE_W:0]  ROUND    = (SIZE_W + 1)'((64'd1 << BLOCK_BYTES_LOG2) - 64'd1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_DONE} state_t;

  state_t                state;
  logic [IDX_W-1:0]      clr_addr;
  logic [IDX_W-1:0]      scan_addr;
  logic [IDX_W-1:0]      chk_addr;
  logic                  pend;
  logic                  is_free;
  logic [FIELD_ID_W-1:0] fid;
  logic [BLK_W-1:0]      blocks;
  logic [ID_W-1:0]       bump;
  logic [ID_W-1:0]       bump_sum;
  logic [CNT_W-1:0]      count;
  logic [ID_W-1:0]       res_id;
  status_t               res_status;
  logic                  rsp_valid;
  logic [FIELD_ID_W-1:0] out_id;
  logic [STATUS_W-1:0]   out_status;
  logic [USED_W-1:0]     out_used;
  logic [FIELD_ID_W-1:0] out_next;

  logic [SIZE_W:0]  size_round;
  logic [BLK_W-1:0] blocks_in;
  logic [SUM_W-1:0] sum;
  logic             disabled;
  logic             rd_entry_valid;
  logic [ID_W-1:0]  rd_start;
  logic             entry_match;
  logic             hit;
  logic             miss;

  always_comb begin
    size_round     = {1'b0, req.size_bytes} + ROUND;
    blocks_in      = BLK_W'(size_round >> BLOCK_BYTES_LOG2);
    sum            = SUM_W'(bump) + SUM_W'(blocks);
    disabled       = !swap_enable || (region_blocks == '0);
    rd_entry_valid = mem_rd_data[ID_W];
    rd_start       = mem_rd_data[ID_W-1:0];
    entry_match    = is_free ? (rd_entry_valid && (CMP_W'(rd_start) == CMP_W'(fid)))
                             : !rd_entry_valid;
    hit            = (state == S_SCAN) && pend && entry_match;
    miss           = (state == S_SCAN) && pend && !entry_match && (chk_addr == LAST_IDX);
  end

  // Clearing pass writes zero; a hit writes the claimed or released entry.
  assign mem_wr_en   = (state == S_CLEAR) || hit;
  assign mem_wr_addr = (state == S_CLEAR) ? clr_addr : chk_addr;
  assign mem_wr_data = ((state == S_SCAN) && !is_free) ? {1'b1, bump} : '0;
  assign mem_rd_addr = scan_addr;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.block_id    = out_id;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_used;
  assign rsp.next_block  = out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      scan_addr <= '0;
      pend      <= 1'b0;
      bump      <= ID_W'(1);
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr == LAST_IDX) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            is_free   <= (req.operation == OP_FREE);
            fid       <= req.free_block_id;
            blocks    <= blocks_in;
            res_id    <= '0;
            scan_addr <= '0;
            pend      <= 1'b0;
            if (req.operation == OP_FREE) begin
              if (req.free_block_id == '0) begin
                res_status <= ST_IGNORED;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end else if (disabled) begin
              res_status <= ST_DISABLED;
              state      <= S_DONE;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          bump_sum <= ID_W'(sum);
          if (sum > SUM_W'(region_blocks)) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (!is_free) begin
              res_id <= bump;
              bump   <= bump_sum;
              count  <= count + CNT_W'(1);
            end else begin
              count <= count - CNT_W'(1);
            end
            res_status <= ST_OK;
            state      <= S_DONE;
          end else if (miss) begin
            res_status <= is_free ? ST_IGNORED : ST_NO_ENTRY;
            state      <= S_DONE;
          end else begin
            pend     <= 1'b1;
            chk_addr <= scan_addr;
            if (scan_addr != LAST_IDX) begin
              scan_addr <= scan_addr + IDX_W'(1);
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            out_id     <= FIELD_ID_W'(res_id);
            out_status <= res_status;
            out_used   <= USED_W'(count);
            out_next   <= FIELD_ID_W'(bump);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "swap_block_table_allocator_unit_macros.svh"

  `SBTA_ASSERT_NOW(a_wr_only_clear_or_scan, clk, rst, mem_wr_en, (state == S_CLEAR || state == S_SCAN), "table write outside clear or scan")
  `SBTA_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, (count <= CNT_W'(ENTRIES)), "entry count exceeds table depth")
  `SBTA_ASSERT_NEXT(a_accept_busy, clk, rst, (req.valid && req.ready), (state != S_IDLE), "engine idle after accepting a request")
  `SBTA_ASSERT_NEXT(a_hit_done, clk, rst, hit, (state == S_DONE), "table hit did not finish the request")

endmodule

// ===== rtl/core/swap_block_table_allocator_unit.sv =====
// Top level of the swap block table allocator: configuration registers,
// request sequencer and entry table. Depends on sbta_pkg, sbta_req_if,
// sbta_rsp_if, sbta_table_mem and sbta_engine.
//
// Use:
//   req carries one transaction per request: operation (allocate or free),
//   size_bytes for allocate, free_block_id for free. rsp returns exactly one
//   transaction per request: block_id, status, entry_count, next_block.
//   Both channels transfer when valid and ready are high at a clock edge.
//   Write swap_enable (index 0) and region_blocks (index 1) with cfg_write
//   only while no request is in flight.
// Timing:
//   One request at a time. Disabled and zero-id free requests go straight to
//   the result; region-full requests first pass the bounds check. The scan
//   checks one entry per cycle and answers at the matching entry or at the
//   last entry. The next request is taken the cycle after the result loads,
//   so each request holds the block until its result loads.
// Reset:
//   rst (synchronous) resets the counters and then runs a clearing pass that
//   writes zero to every table entry; req.ready stays low until it ends.
// Back-pressure:
//   The result waits in the output register while rsp.ready is low; the
//   next request is still accepted and processed, then holds at its end
//   until the output register frees up.
module swap_block_table_allocator_unit #(
  parameter int ENTRIES          = 64,
  parameter int BLOCK_BYTES_LOG2 = 12,
  parameter int BLOCK_ID_BITS    = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sbta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbta_pkg::CFG_W-1:0]     cfg_data,
  sbta_req_if.sink                       req,
  sbta_rsp_if.source                     rsp
);
  import sbta_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int MEM_W = BLOCK_ID_BITS + 1;

  logic             swap_enable;
  logic [CFG_W-1:0] region_blocks;

  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [MEM_W-1:0] mem_wr_data;
  logic [IDX_W-1:0] mem_rd_addr;
  logic [MEM_W-1:0] mem_rd_data;

  // Hold configuration; the user must write only between requests, the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_enable   <= 1'b0;
      region_blocks <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SWAP_ENABLE:   swap_enable   <= cfg_data[0];
        CFG_REGION_BLOCKS: region_blocks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Each entry stores a valid bit above its start block.
  sbta_table_mem #(
    .DEPTH  (ENTRIES),
    .WIDTH  (MEM_W),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Sequence clear, check, scan and write-back; the scan finishes its write
  // before the next request may read, so no forwarding is needed.
  sbta_engine #(
    .ENTRIES          (ENTRIES),
    .BLOCK_BYTES_LOG2 (BLOCK_BYTES_LOG2),
    .BLOCK_ID_BITS    (BLOCK_ID_BITS),
    .IDX_W            (IDX_W)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .swap_enable   (swap_enable),
    .region_blocks (region_blocks),
    .req           (req),
    .rsp           (rsp),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data)
  );

endmodule
